[design/newton_cube_root_assert.svh]
// assertion macros for the newton cube root block
// no dependencies; included by the modules that carry assertions
`ifndef NEWTON_CUBE_ROOT_ASSERT_SVH
`define NEWTON_CUBE_ROOT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define NCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NCR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define NCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define NCR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[design/ncr_pkg.sv]
// shared widths, register indexes, state type and divider status struct
// for the newton cube root block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ncr_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int TOL_W     = 16;
    localparam int ITER_W    = 8;
    localparam int ROOT_W    = 23;

    // iterate width: newton iterates stay below a few times 2^DATA_W
    localparam int X_W    = DATA_W + 2;
    localparam int SQ_W   = 2 * X_W;
    localparam int CUBE_W = 3 * X_W;
    localparam int WIDE_W = CUBE_W + 2;
    localparam int DEN_W  = SQ_W + 2;
    localparam int REM_W  = DEN_W + 1;
    localparam int CNT_W  = $clog2(X_W);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TOL_W;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = CFG_IDX_W'(1);

    localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(1);
    localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(64);

    localparam logic [X_W-1:0] ROOT_MAX = X_W'(1) << (ROOT_W - 2);

    // floor(n/3) = (n * (2^33 + 1)/3) >> 33, exact for any 32-bit n
    localparam logic [X_W-1:0] RECIP3       = X_W'(32'hAAAA_AAAB);
    localparam int             RECIP3_SHIFT = 33;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED,
        S_SQ,
        S_CUBE_LO,
        S_CUBE_HI,
        S_CUBE_SUM,
        S_ABS,
        S_TEST,
        S_STEP_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

[design/ncr_mul.sv]
// shared registered multiplier for the newton cube root block
// depends on ncr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ncr_mul
    import ncr_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic [X_W-1:0]  i_a,
    input  wire logic [X_W-1:0]  i_b,
    output logic      [SQ_W-1:0] o_prod
);

    logic [SQ_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= SQ_W'(i_a) * SQ_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

[design/ncr_div.sv]
// restoring divider, one quotient bit per cycle, for the newton cube root block
// depends on ncr_pkg and newton_cube_root_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "newton_cube_root_assert.svh"

module ncr_div
    import ncr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WIDE_W-1:0] i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic      [X_W-1:0]    o_quot,
    output t_div_stat              o_stat
);

    logic [REM_W-1:0] r_rem;
    logic [X_W-1:0]   r_low;
    logic [DEN_W-1:0] r_den;
    logic [X_W-1:0]   r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [REM_W-1:0] trial;
    logic             fits;

    // shift in the next numerator bit and try the subtract
    assign trial = {r_rem[REM_W-2:0], r_low[X_W-1]};
    assign fits  = trial >= REM_W'(r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(X_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // upper part is below the divisor since the quotient fits X_W bits
            r_rem <= REM_W'(i_num[WIDE_W-1:X_W]);
            r_low <= i_num[X_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem  <= fits ? (trial - REM_W'(r_den)) : trial;
            r_low  <= {r_low[X_W-2:0], 1'b0};
            r_quot <= {r_quot[X_W-2:0], fits};
        end
    end

    assign o_quot      = r_quot;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    `NCR_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_start, !r_busy, "divider restarted while busy")
    `NCR_ASSERT_NXT(a_last_done, i_clk, i_rst_n, r_busy && r_cnt == '0 && !i_start, r_done, "divider missed done")
    `NCR_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, !r_busy, "divider done while busy")

endmodule

`default_nettype wire

[design/newton_cube_root.sv]
// newton cube root, signed q16.16: one request at a time, ready only when idle
// a result follows the seed y/3 (reciprocal multiply) and k newton steps: each
// pass runs a tolerance check and, when it fails below the step cap, a step divide
// on the bit-serial divider
// a new request waits until the result has been handed off and the block is idle
// reset (synchronous, active low): idle, tolerance = 1, max_iterations = 64
`timescale 1ns / 1ps
`default_nettype none
`include "newton_cube_root_assert.svh"

module newton_cube_root
    import ncr_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request channel
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic signed [DATA_W-1:0]    i_value,
    // result channel
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic signed      [ROOT_W-1:0]    o_root,
    output logic                             o_converged,
    // register writes
    input  wire logic                        i_cfg_we,
    input  wire logic        [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic        [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    // configuration
    logic [TOL_W-1:0]  r_tol;
    logic [ITER_W-1:0] r_max_it;

    // working values; y and tolerance are scaled by 2^(2*frac)
    logic              r_neg;
    logic              r_nz;
    logic [WIDE_W-1:0] r_y;
    logic [X_W-1:0]    r_x;
    logic [SQ_W-1:0]   r_x2;
    logic [CUBE_W-1:0] r_x3;
    logic [WIDE_W-1:0] r_diff;
    logic [ITER_W-1:0] r_steps;

    // result hold register
    logic [ROOT_W-1:0] r_root;
    logic              r_conv;

    // shared unit hookup
    logic [X_W-1:0]    mul_a, mul_b;
    logic [SQ_W-1:0]   mul_p;
    logic              div_start;
    logic [WIDE_W-1:0] div_num;
    logic [DEN_W-1:0]  div_den;
    logic [X_W-1:0]    div_q;
    t_div_stat         div_stat;

    logic [DATA_W-1:0] in_mag;
    logic              in_acc;
    logic              out_acc;
    logic [X_W-1:0]    seed_q;
    logic [WIDE_W-1:0] x3_wide;
    logic [WIDE_W-1:0] tol_wide;
    logic              tol_pass;
    logic              cap_hit;
    logic [X_W-1:0]    x_sat;
    logic [ROOT_W-1:0] root_mag;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    // magnitude of the operand; the most negative code maps to 2^(DATA_W-1)
    assign in_mag = i_value[DATA_W-1] ? DATA_W'(-i_value) : DATA_W'(i_value);

    // |y| / 3 from the reciprocal product taken at acceptance
    assign seed_q = X_W'(mul_p >> RECIP3_SHIFT);

    assign x3_wide  = WIDE_W'(r_x3);
    assign tol_wide = WIDE_W'(r_tol) << (2 * FRAC_BITS);
    assign tol_pass = r_diff <= tol_wide;
    assign cap_hit  = r_steps >= r_max_it;

    // clamp only matters for a result that did not converge
    assign x_sat    = (r_x > ROOT_MAX) ? ROOT_MAX : r_x;
    assign root_mag = ROOT_W'(x_sat);

    ncr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    ncr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (div_q),
        .o_stat  (div_stat)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_valid) n_state = S_SEED;
            S_SEED:     n_state = S_SQ;
            S_SQ:       n_state = S_CUBE_LO;
            S_CUBE_LO:  n_state = S_CUBE_HI;
            S_CUBE_HI:  n_state = S_CUBE_SUM;
            S_CUBE_SUM: n_state = S_ABS;
            S_ABS:      n_state = S_TEST;
            S_TEST:     n_state = (tol_pass || cap_hit) ? S_DONE : S_STEP_DIV;
            S_STEP_DIV: if (div_stat.done) n_state = S_SQ;
            S_DONE:     if (i_ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // unit operand selection per state
    always_comb begin
        o_ready   = 1'b0;
        o_valid   = 1'b0;
        mul_a     = r_x;
        mul_b     = r_x;
        div_start = 1'b0;
        div_num   = r_y + (x3_wide << 1);
        div_den   = DEN_W'(r_x2) + (DEN_W'(r_x2) << 1);
        case (r_state)
            S_IDLE: begin
                // seed: |y| times the reciprocal of 3
                o_ready = 1'b1;
                mul_a   = X_W'(in_mag);
                mul_b   = RECIP3;
            end
            S_CUBE_LO: begin
                // low half of x^2 times x
                mul_a = mul_p[X_W-1:0];
            end
            S_CUBE_HI: begin
                // high half of x^2 times x
                mul_a = r_x2[SQ_W-1:X_W];
            end
            S_TEST: begin
                // newton step: (y + 2x^3) / (3x^2)
                div_start = !(tol_pass || cap_hit);
            end
            S_DONE: begin
                o_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tol    <= TOL_RESET;
            r_max_it <= ITER_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TOLERANCE: r_tol    <= i_cfg_data[TOL_W-1:0];
                    REG_MAX_ITER:  r_max_it <= i_cfg_data[ITER_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_neg   <= i_value[DATA_W-1];
                    r_nz    <= in_mag != '0;
                    r_y     <= WIDE_W'(in_mag) << (2 * FRAC_BITS);
                    r_steps <= '0;
                end
            end
            S_SEED: begin
                // a zero seed for a nonzero operand becomes one lsb
                r_x <= (seed_q == '0 && r_nz) ? X_W'(1) : seed_q;
            end
            S_CUBE_LO: begin
                r_x2 <= mul_p;
            end
            S_CUBE_HI: begin
                r_x3 <= CUBE_W'(mul_p);
            end
            S_CUBE_SUM: begin
                r_x3 <= r_x3 + (CUBE_W'(mul_p) << X_W);
            end
            S_ABS: begin
                r_diff <= (x3_wide >= r_y) ? (x3_wide - r_y) : (r_y - x3_wide);
            end
            S_TEST: begin
                if (tol_pass || cap_hit) begin
                    r_root <= r_neg ? (-root_mag) : root_mag;
                    r_conv <= tol_pass;
                end
            end
            S_STEP_DIV: begin
                if (div_stat.done) begin
                    r_x     <= div_q;
                    r_steps <= r_steps + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_root      = r_root;
    assign o_converged = r_conv;

    `NCR_ASSERT_IMP(a_idle_div_free, i_clk, i_rst_n, r_state == S_IDLE, !div_stat.busy, "divider busy while idle")
    `NCR_ASSERT_IMP(a_steps_capped, i_clk, i_rst_n, r_state == S_TEST, r_steps <= r_max_it, "step count beyond cap")
    `NCR_ASSERT_NXT(a_result_held, i_clk, i_rst_n, o_valid && !i_ready, $stable(r_root) && $stable(r_conv), "result changed while waiting")
    `NCR_ASSERT_NXT(a_accept_to_seed, i_clk, i_rst_n, in_acc, r_state == S_SEED, "seed not started")

endmodule

`default_nettype wire

[tb/sv/tb_newton_cube_root.sv]
// self-checking testbench for newton_cube_root: random and directed requests,
// an in-bench newton predictor, and random stalls on both handshakes; uses ncr_pkg
`timescale 1ns / 1ps

module tb_newton_cube_root;
    import ncr_pkg::*;

    // a stalled request can wait out a full 255-step solve plus a long hold-off
    localparam int unsigned WATCHDOG_LIMIT = 60000;
    // result count at which the receiver stops taking results for a while
    localparam int unsigned PRESSURE_AT    = 40;
    localparam int unsigned PRESSURE_HOLD  = 1500;
    localparam int unsigned DRAIN_CYCLES   = 100;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic              converged;
    } cube_root_t;

    // corner operands: zero, one lsb either side, the tiny magnitudes whose
    // y/3 seed is zero, exact cubes, both ends of the range, a plain fraction
    localparam logic [DATA_W-1:0] CORNERS [18] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002,
        32'hFFFF_FFFE, 32'h0000_0003, 32'hFFFF_FFFD, 32'h0001_0000,
        32'hFFFF_0000, 32'h0008_0000, 32'hFFE5_0000, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h8000_0001, 32'h03E8_0000, 32'h0000_8000,
        32'h745F_0000, 32'h5555_5555
    };

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_valid    = 1'b0;
    logic                          o_ready;
    logic signed [DATA_W-1:0]      i_value    = '0;
    logic                          o_valid;
    logic                          i_ready    = 1'b0;
    logic signed [ROOT_W-1:0]      o_root;
    logic                          o_converged;
    logic                          i_cfg_we   = 1'b0;
    logic        [CFG_IDX_W-1:0]   i_cfg_idx  = REG_TOLERANCE;
    logic        [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // bench copy of the two registers, kept in step with every write
    logic [TOL_W-1:0]  tol_shadow  = TOL_RESET;
    logic [ITER_W-1:0] iter_shadow = ITER_RESET;

    logic [DATA_W-1:0] operand_q[$];       // requests not yet offered
    cube_root_t        expected_roots[$];  // predicted results, oldest first

    bit          calm       = 1'b0;        // when set, neither side idles
    int unsigned n_errors   = 0;
    int unsigned n_results  = 0;
    int unsigned send_gap   = 0;
    int unsigned recv_gap   = 0;
    int unsigned hold_left  = 0;
    int unsigned quiet_cnt  = 0;

    newton_cube_root i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_root      (o_root),
        .o_converged (o_converged),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // newton iteration on magnitudes with 256-bit intermediates, sign put back
    // at the end; x^3 and y are both scaled to 3*FRAC_BITS fraction bits
    function automatic cube_root_t predict_root(input logic [DATA_W-1:0] y);
        logic [255:0]      mag, y_sc, tol_sc, x, x_sq, x_cu, err;
        logic [DATA_W-1:0] y_neg;
        int unsigned       steps;
        bit                hit;
        cube_root_t        r;
        y_neg  = -y;
        mag    = y[DATA_W-1] ? 256'(y_neg) : 256'(y);
        y_sc   = mag << (2 * FRAC_BITS);
        tol_sc = 256'(tol_shadow) << (2 * FRAC_BITS);
        x      = mag / 3;
        // seed of zero for a nonzero operand becomes one lsb
        if (x == 0 && mag != 0) begin
            x = 256'd1;
        end
        steps = 0;
        hit   = 1'b0;
        while (1'b1) begin
            x_sq = x * x;
            x_cu = x_sq * x;
            err  = (x_cu >= y_sc) ? x_cu - y_sc : y_sc - x_cu;
            // tolerance is tested on the seed too, before any step
            if (err <= tol_sc) begin
                hit = 1'b1;
                break;
            end
            if (steps >= iter_shadow) begin
                break;
            end
            x = (y_sc + x_cu + x_cu) / (x_sq * 3);
            x = {192'd0, x[63:0]};
            steps++;
        end
        // only a root that gave up can be this large
        if (x > 256'(ROOT_MAX)) begin
            x = 256'(ROOT_MAX);
        end
        r.root      = y[DATA_W-1] ? ROOT_W'(-x) : ROOT_W'(x);
        r.converged = hit;
        return r;
    endfunction

    // back to back or a short gap most of the time, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 40) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 60);
        end else begin
            return $urandom_range(100, 400);
        end
    endfunction

    // operand mix: full-range noise, tiny magnitudes, mid range, exact cubes,
    // values near the ends of the range and powers of two, either sign
    function automatic logic [DATA_W-1:0] pick_operand();
        int unsigned       roll, k;
        logic [DATA_W-1:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            v = $urandom;
        end else if (roll < 50) begin
            v = DATA_W'($urandom_range(0, 7));
        end else if (roll < 65) begin
            v = DATA_W'($urandom_range(1 << 16, 1 << 24));
        end else if (roll < 80) begin
            k = $urandom_range(0, 31);
            v = DATA_W'((k * k * k) << FRAC_BITS);
        end else if (roll < 90) begin
            v = 32'h7FFF_FFFF - DATA_W'($urandom_range(0, 255));
        end else begin
            v = DATA_W'(1) << $urandom_range(0, DATA_W - 2);
        end
        if ($urandom_range(0, 1) == 1) begin
            v = -v;
        end
        return v;
    endfunction

    // request driver: holds a request until taken, predicts it on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && o_ready) begin
                expected_roots.push_back(predict_root(i_value));
            end
            if (i_valid && !o_ready) begin
                // stalled: keep the request and its value as they are
            end else if (send_gap != 0) begin
                i_valid <= 1'b0;
                send_gap--;
            end else if (operand_q.size() != 0) begin
                i_valid <= 1'b1;
                i_value <= operand_q.pop_front();
                send_gap = pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result monitor: checks each taken result and paces i_ready
    always @(posedge i_clk) begin : result_check
        cube_root_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_roots.size() == 0) begin
                    $error("result with no request pending: root %h converged %b",
                           o_root, o_converged);
                    n_errors++;
                end else begin
                    want = expected_roots.pop_front();
                    if (o_root !== want.root) begin
                        $error("root: expected %h, got %h", want.root, o_root);
                        n_errors++;
                    end
                    if (o_converged !== want.converged) begin
                        $error("converged: expected %b, got %b",
                               want.converged, o_converged);
                        n_errors++;
                    end
                end
                n_results++;
                // one long hold-off so the block fills and stalls its input
                if (n_results == PRESSURE_AT) begin
                    hold_left = PRESSURE_HOLD;
                end else begin
                    recv_gap = pick_gap();
                end
            end
            if (hold_left != 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (recv_gap != 0) begin
                i_ready <= 1'b0;
                recv_gap--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog: too long with neither a request nor a result taken
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cnt = 0;
            end else if (quiet_cnt == WATCHDOG_LIMIT) begin
                $display("watchdog expired after %0d idle cycles", quiet_cnt);
                $display("tb_newton_cube_root: done, errors");
                $finish;
            end else begin
                quiet_cnt++;
            end
        end
    end

    // block is idle once nothing is queued, offered or awaited; sampled on the
    // falling edge so the driver's updates of the rising edge have settled
    task automatic wait_drained();
        while (operand_q.size() != 0 || i_valid || expected_roots.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // writes both registers on back-to-back edges, block idle
    task automatic write_regs(input logic [TOL_W-1:0] tol, input logic [ITER_W-1:0] iter);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_TOLERANCE;
        i_cfg_data <= CFG_DATA_W'(tol);
        tol_shadow = tol;
        @(posedge i_clk);
        i_cfg_idx  <= REG_MAX_ITER;
        i_cfg_data <= CFG_DATA_W'(iter);
        iter_shadow = iter;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [TOL_W-1:0] tol, input logic [ITER_W-1:0] iter,
                             input int unsigned count, input bit quiet);
        wait_drained();
        write_regs(tol, iter);
        @(negedge i_clk);
        calm = quiet;
        for (int unsigned n = 0; n < count; n++) begin
            operand_q.push_back(pick_operand());
        end
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners under the reset register values
        @(negedge i_clk);
        foreach (CORNERS[n]) begin
            operand_q.push_back(CORNERS[n]);
        end

        // loosest tolerance with the highest cap; the hold-off lands here
        run_phase(16'hFFFF, 8'd255, 80, 1'b0);
        // exact match with a single step: mostly gives up, big roots saturate
        run_phase(16'h0000, 8'd1, 80, 1'b1);
        // random settings with short caps
        for (int unsigned p = 0; p < 6; p++) begin
            run_phase(TOL_W'($urandom_range(0, 65535)), ITER_W'($urandom_range(1, 20)),
                      20, 1'b0);
        end
        // back to reset values, then a moderate setting
        run_phase(TOL_RESET, ITER_RESET, 60, 1'b0);
        run_phase(16'd300, 8'd40, 60, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_newton_cube_root: done, clean");
        end else begin
            $display("tb_newton_cube_root: done, errors");
        end
        $finish;
    end

endmodule
